[hdl/dmaf_pkg.sv]
// ----------------------------------------------------------------------------
// dmaf_pkg
// shared codes, register indexes and interface types of the mode agreement
// block
// ----------------------------------------------------------------------------
package dmaf_pkg;

    localparam int DEF_MAX_STATIONS = 32;

    // station state codes, bit1 reset flag, bit0 run flag
    localparam logic [1:0] CODE_EXIT  = 2'd0;
    localparam logic [1:0] CODE_RUN   = 2'd1;
    localparam logic [1:0] CODE_RESET = 2'd2;
    localparam logic [1:0] CODE_READY = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_INDEX   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATION_COUNT = 2'd1;

    localparam int SLOT_W  = 5;
    localparam int COUNT_W = 6;

    typedef struct packed {
        logic       clear;
        logic       take;
        logic       hit;
        logic [1:0] mid_code;
    } scan_ctrl_t;

    typedef struct packed {
        logic all_reset;
        logic any_reset;
        logic all_run;
    } scan_res_t;

endpackage

[hdl/dmaf_table.sv]
// ----------------------------------------------------------------------------
// dmaf_table
// station flag memory, one write and one registered read port, with
// per-entry valid bits so unwritten entries read as exit
// ----------------------------------------------------------------------------
module dmaf_table #(
    parameter int MAX_STATIONS = dmaf_pkg::DEF_MAX_STATIONS,
    parameter int IDXW         = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  logic [IDXW-1:0] wr_addr,
    input  logic [1:0]      wr_data,
    input  logic            rd_en,
    input  logic [IDXW-1:0] rd_addr,
    output logic [1:0]      rd_data
);

    logic [1:0]              mem [MAX_STATIONS];
    logic [MAX_STATIONS-1:0] valid_reg;
    logic [1:0]              rd_data_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written entries read as exit
    assign rd_data = rd_valid_reg ? rd_data_reg : dmaf_pkg::CODE_EXIT;

endmodule

[hdl/dmaf_scan.sv]
// ----------------------------------------------------------------------------
// dmaf_scan
// shared check unit: folds one table entry per cycle, while take is high,
// into the all-reset, any-reset and all-run results
// ----------------------------------------------------------------------------
module dmaf_scan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dmaf_pkg::scan_ctrl_t  ctrl,
    input  logic [1:0]            rd_data,
    output dmaf_pkg::scan_res_t   res
);

    logic       all_reset_reg;
    logic       any_reset_reg;
    logic       all_run_reg;
    logic [1:0] flags;

    // the local slot is seen with its updated code
    assign flags = ctrl.hit ? ctrl.mid_code : rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_reset_reg <= 1'b1;
            any_reset_reg <= 1'b0;
            all_run_reg   <= 1'b1;
        end
        else if (ctrl.clear)
        begin
            all_reset_reg <= 1'b1;
            any_reset_reg <= 1'b0;
            all_run_reg   <= 1'b1;
        end
        else if (ctrl.take)
        begin
            all_reset_reg <= all_reset_reg & flags[1];
            any_reset_reg <= any_reset_reg | flags[1];
            all_run_reg   <= all_run_reg & flags[0];
        end
    end

    assign res.all_reset = all_reset_reg;
    assign res.any_reset = any_reset_reg;
    assign res.all_run   = all_run_reg;

`ifndef NO_ASSERTIONS
    a_any_vs_all: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ctrl.take) && !$past(ctrl.clear) && !$past(all_reset_reg)
            |-> !all_reset_reg)
        else $error("all-reset result recovered without a clear");
`endif

endmodule

[hdl/distributed_mode_agreement_fsm.sv]
// ----------------------------------------------------------------------------
// distributed_mode_agreement_fsm
// station mode agreement machine: stores peer status reports in a flag
// table and steps the local exit/reset/ready/run machine
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_*       in         one peer status report
//  m_*       out        local state, broadcast count, removal clear pulse
//  cfg_*     in         register write: 0 local_index, 1 station_count
//
//  with n = min(station_count, MAX_STATIONS), a report taken in idle passes
//  through the access, local, scan and decide states; the scan covers n
//  entries, the check unit reading one table entry per cycle through the
//  single table read port
//  s_tready is high only while the machine is idle; a stalled result waits in
//  the output register, and the next report is taken once it has been stored
//  reset clears the table valid bits, local_index to 0, station_count to 1
//  cfg_ready is always high; writes belong to idle periods
// ----------------------------------------------------------------------------
module distributed_mode_agreement_fsm #(
    parameter int MAX_STATIONS = dmaf_pkg::DEF_MAX_STATIONS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // peer_index[4:0], peer_reset, peer_run
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // local_state[1:0], broadcasts[1:0], clear_removal
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dmaf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dmaf_pkg::COUNT_W-1:0]   cfg_data
);

    localparam int IDXW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
    localparam int CNTW = $clog2(MAX_STATIONS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_LOCAL,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t                        state_reg;
    logic [dmaf_pkg::SLOT_W-1:0]   local_index_reg;
    logic [dmaf_pkg::COUNT_W-1:0]  station_count_reg;
    logic [IDXW-1:0]               peer_reg;
    logic [IDXW-1:0]               me_reg;
    logic [1:0]                    pcode_reg;
    logic [1:0]                    lcode_reg;
    logic [1:0]                    mid_reg;
    logic [CNTW-1:0]               scan_cnt_reg;
    logic                          pend_reg;
    logic [IDXW-1:0]               pend_addr_reg;
    logic                          m_tvalid_reg;
    logic [4:0]                    m_data_reg;

    logic [CNTW-1:0]               scan_len;
    logic                          scan_empty;
    logic                          out_free;
    logic                          tbl_wr_en;
    logic [IDXW-1:0]               tbl_wr_addr;
    logic [1:0]                    tbl_wr_data;
    logic                          tbl_rd_en;
    logic [IDXW-1:0]               tbl_rd_addr;
    logic [1:0]                    tbl_rd_data;
    logic [1:0]                    mid_code;
    logic [1:0]                    fin_code;
    logic [1:0]                    sends;
    logic                          clr;
    dmaf_pkg::scan_ctrl_t          scan_ctrl;
    dmaf_pkg::scan_res_t           scan_res;

    // slot wrap as a small constant table
    function automatic logic [IDXW-1:0] slot_of(input logic [dmaf_pkg::SLOT_W-1:0] v);
        logic [IDXW-1:0] r;
        r = '0;
        for (int k = 0; k < (1 << dmaf_pkg::SLOT_W); k++)
        begin
            if (v == dmaf_pkg::SLOT_W'(k))
            begin
                r = IDXW'(k % MAX_STATIONS);
            end
        end
        return r;
    endfunction

    always_comb
    begin
        if (32'(station_count_reg) > 32'(MAX_STATIONS))
        begin
            scan_len = CNTW'(MAX_STATIONS);
        end
        else
        begin
            scan_len = CNTW'(station_count_reg);
        end
    end

    assign scan_empty = (station_count_reg == '0);
    assign out_free   = !m_tvalid_reg || m_tready;

    // final decision from the local code, peer code and check results
    always_comb
    begin
        fin_code = lcode_reg;
        sends    = 2'd0;
        clr      = 1'b0;
        case (lcode_reg)
            dmaf_pkg::CODE_EXIT:
            begin
                if (pcode_reg == dmaf_pkg::CODE_RESET)
                begin
                    fin_code = dmaf_pkg::CODE_RESET;
                    sends    = 2'd1;
                    clr      = 1'b1;
                end
            end
            dmaf_pkg::CODE_RESET:
            begin
                if (pcode_reg == dmaf_pkg::CODE_RESET || pcode_reg == dmaf_pkg::CODE_READY)
                begin
                    if (!scan_empty && scan_res.all_reset)
                    begin
                        fin_code = dmaf_pkg::CODE_READY;
                        sends    = 2'd1;
                    end
                end
                else if (pcode_reg == dmaf_pkg::CODE_EXIT && !scan_res.any_reset)
                begin
                    fin_code = dmaf_pkg::CODE_EXIT;
                    sends    = 2'd1;
                end
            end
            dmaf_pkg::CODE_READY:
            begin
                if (pcode_reg == dmaf_pkg::CODE_READY || pcode_reg == dmaf_pkg::CODE_RUN)
                begin
                    if (!scan_empty && scan_res.all_run)
                    begin
                        fin_code = dmaf_pkg::CODE_RUN;
                        sends    = 2'd1;
                    end
                end
                else if (pcode_reg == dmaf_pkg::CODE_EXIT)
                begin
                    fin_code = dmaf_pkg::CODE_EXIT;
                    sends    = 2'd1;
                end
            end
            default:
            begin
                fin_code = mid_reg;
                if (mid_reg != lcode_reg)
                begin
                    sends = 2'd1;
                end
                // second exit when a scanned station is not running
                if (!scan_res.all_run)
                begin
                    fin_code = dmaf_pkg::CODE_EXIT;
                    sends    = sends + 2'd1;
                end
            end
        endcase
    end

    // run state drops to exit on a peer in exit or reset before the scan
    always_comb
    begin
        mid_code = tbl_rd_data;
        if (tbl_rd_data == dmaf_pkg::CODE_RUN &&
            (pcode_reg == dmaf_pkg::CODE_EXIT || pcode_reg == dmaf_pkg::CODE_RESET))
        begin
            mid_code = dmaf_pkg::CODE_EXIT;
        end
    end

    // table port steering
    always_comb
    begin
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = peer_reg;
        tbl_wr_data = pcode_reg;
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = me_reg;
        case (state_reg)
            ST_ACCESS:
            begin
                tbl_wr_en = (peer_reg != me_reg);
                tbl_rd_en = 1'b1;
            end
            ST_SCAN:
            begin
                tbl_rd_en   = (scan_cnt_reg < scan_len);
                tbl_rd_addr = scan_cnt_reg[IDXW-1:0];
            end
            ST_DECIDE:
            begin
                tbl_wr_en   = out_free;
                tbl_wr_addr = me_reg;
                tbl_wr_data = fin_code;
            end
            default:
            begin
                tbl_wr_en = 1'b0;
            end
        endcase
    end

    assign scan_ctrl.clear    = (state_reg == ST_LOCAL);
    assign scan_ctrl.take     = (state_reg == ST_SCAN) && pend_reg;
    assign scan_ctrl.hit      = (pend_addr_reg == me_reg);
    assign scan_ctrl.mid_code = mid_reg;

    dmaf_table #(
        .MAX_STATIONS (MAX_STATIONS),
        .IDXW         (IDXW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    dmaf_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (scan_ctrl),
        .rd_data (tbl_rd_data),
        .res     (scan_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            local_index_reg   <= '0;
            station_count_reg <= dmaf_pkg::COUNT_W'(1);
            scan_cnt_reg      <= '0;
            pend_reg          <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == dmaf_pkg::REG_LOCAL_INDEX)
                begin
                    local_index_reg <= cfg_data[dmaf_pkg::SLOT_W-1:0];
                end
                else if (cfg_index == dmaf_pkg::REG_STATION_COUNT)
                begin
                    station_count_reg <= cfg_data;
                end
            end

            // a new result beat takes the output register as the old one leaves
            if (state_reg == ST_DECIDE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_ACCESS;
                    end
                end
                ST_ACCESS:
                begin
                    state_reg <= ST_LOCAL;
                end
                ST_LOCAL:
                begin
                    scan_cnt_reg <= '0;
                    pend_reg     <= 1'b0;
                    state_reg    <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (scan_cnt_reg < scan_len)
                    begin
                        scan_cnt_reg <= scan_cnt_reg + CNTW'(1);
                        pend_reg     <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                end
                ST_DECIDE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            peer_reg  <= slot_of(s_tdata[4:0]);
            me_reg    <= slot_of(local_index_reg);
            pcode_reg <= {s_tdata[5], s_tdata[6]};
        end
        if (state_reg == ST_LOCAL)
        begin
            lcode_reg <= tbl_rd_data;
            mid_reg   <= mid_code;
        end
        if (state_reg == ST_SCAN)
        begin
            pend_addr_reg <= scan_cnt_reg[IDXW-1:0];
        end
        if (state_reg == ST_DECIDE && out_free)
        begin
            m_data_reg <= {clr, sends, fin_code};
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {3'b000, m_data_reg};
    assign cfg_ready = 1'b1;

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("report accepted while another is in progress");

    a_sends_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:2] != 2'd3)
        else $error("broadcast count out of range");

    a_clear_on_reset_entry: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[1:0] == dmaf_pkg::CODE_RESET &&
                                   m_tdata[3:2] == 2'd1)
        else $error("removal clear without entering reset");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> scan_cnt_reg <= scan_len)
        else $error("scan counter ran past the station count");
`endif

endmodule

[tb/tb_distributed_mode_agreement_fsm.sv]
// ----------------------------------------------------------------------------
// tb_distributed_mode_agreement_fsm
// self-checking bench for the station mode agreement machine: peer status
// reports go in on the slave stream, and a local copy of the flag table and
// the exit/reset/ready/run machine predicts every result beat, which is
// compared field by field. Runs directed corner cases, random agreement
// rounds under several idle mixes and a long output stall.
// ----------------------------------------------------------------------------
module tb_distributed_mode_agreement_fsm;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 40;

    typedef logic [dmaf_pkg::SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic [1:0] state;
        logic [1:0] sends;
        logic       clr;
    } outcome_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;    // peer_index[4:0], peer_reset, peer_run
    logic                           m_tvalid;
    logic                           m_tready;
    logic [7:0]                     m_tdata;    // local_state[1:0], broadcasts[1:0], clear_removal
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [dmaf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dmaf_pkg::COUNT_W-1:0]   cfg_data;

    // predictor state
    logic [1:0] flags [dmaf_pkg::DEF_MAX_STATIONS];
    slot_t      my_slot;
    int         scan_count;

    outcome_t   pending [$];
    int         mismatches;
    int         reports_sent;
    int         send_gap;
    int         recv_gap;
    int         hold_left;
    int         quiet;

    distributed_mode_agreement_fsm uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, want %0d", what, got, want);
        mismatches++;
    endtask

    // scans the first scan_count entries, capped at the table size, for flag bit b
    function automatic void scan_flags(input int b, output bit all_on, output bit some_on,
                                       output bit some_off);
        int n;
        n = (scan_count > dmaf_pkg::DEF_MAX_STATIONS) ? dmaf_pkg::DEF_MAX_STATIONS : scan_count;
        all_on   = (n != 0);
        some_on  = 1'b0;
        some_off = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (flags[i][b])
                some_on = 1'b1;
            else
            begin
                some_off = 1'b1;
                all_on   = 1'b0;
            end
        end
    endfunction

    function automatic outcome_t apply_report(input slot_t peer, input logic [1:0] pcode);
        outcome_t o;
        int       sends;
        bit       clr;
        bit       all_on;
        bit       some_on;
        bit       some_off;
        sends = 0;
        clr   = 1'b0;
        // a report naming our own slot only drives the machine
        if (peer != my_slot)
            flags[peer] = pcode;
        case (flags[my_slot])
            dmaf_pkg::CODE_EXIT:
            begin
                if (pcode == dmaf_pkg::CODE_RESET)
                begin
                    flags[my_slot] = dmaf_pkg::CODE_RESET;
                    sends = 1;
                    clr   = 1'b1;
                end
            end
            dmaf_pkg::CODE_RESET:
            begin
                scan_flags(1, all_on, some_on, some_off);
                if ((pcode == dmaf_pkg::CODE_RESET || pcode == dmaf_pkg::CODE_READY) && all_on)
                begin
                    flags[my_slot] = dmaf_pkg::CODE_READY;
                    sends = 1;
                end
                else if (pcode == dmaf_pkg::CODE_EXIT && !some_on)
                begin
                    flags[my_slot] = dmaf_pkg::CODE_EXIT;
                    sends = 1;
                end
            end
            dmaf_pkg::CODE_READY:
            begin
                scan_flags(0, all_on, some_on, some_off);
                if ((pcode == dmaf_pkg::CODE_READY || pcode == dmaf_pkg::CODE_RUN) && all_on)
                begin
                    flags[my_slot] = dmaf_pkg::CODE_RUN;
                    sends = 1;
                end
                else if (pcode == dmaf_pkg::CODE_EXIT)
                begin
                    flags[my_slot] = dmaf_pkg::CODE_EXIT;
                    sends = 1;
                end
            end
            default:
            begin
                if (pcode == dmaf_pkg::CODE_EXIT || pcode == dmaf_pkg::CODE_RESET)
                begin
                    flags[my_slot] = dmaf_pkg::CODE_EXIT;
                    sends++;
                end
                // second check sees the table after the first drop
                scan_flags(0, all_on, some_on, some_off);
                if (some_off)
                begin
                    flags[my_slot] = dmaf_pkg::CODE_EXIT;
                    sends++;
                end
            end
        endcase
        o.state = flags[my_slot];
        o.sends = sends[1:0];
        o.clr   = clr;
        return o;
    endfunction

    task automatic send_report(input slot_t idx, input logic [1:0] code);
        while ($urandom_range(0, 99) < send_gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, code[0], code[1], idx};
        do
            @(posedge clk);
        while (!s_tready);
        pending.push_back(apply_report(idx, code));
        reports_sent++;
    endtask

    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    // both registers back to back, valid held high across the two beats
    task automatic set_config(input int li, input int sc);
        cfg_valid <= 1'b1;
        cfg_index <= dmaf_pkg::REG_LOCAL_INDEX;
        cfg_data  <= dmaf_pkg::COUNT_W'(li);
        do
            @(posedge clk);
        while (!cfg_ready);
        my_slot   = slot_t'(li);
        cfg_index <= dmaf_pkg::REG_STATION_COUNT;
        cfg_data  <= dmaf_pkg::COUNT_W'(sc);
        do
            @(posedge clk);
        while (!cfg_ready);
        scan_count = sc;
        cfg_valid <= 1'b0;
    endtask

    // result beats: check and drive ready
    always @(posedge clk)
    begin : result_side
        outcome_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending.size() == 0)
                    report_mismatch("result beat with nothing expected", int'(m_tdata), 0);
                else
                begin
                    want = pending.pop_front();
                    if (m_tdata[1:0] != want.state)
                        report_mismatch("local_state", int'(m_tdata[1:0]), int'(want.state));
                    if (m_tdata[3:2] != want.sends)
                        report_mismatch("broadcasts", int'(m_tdata[3:2]), int'(want.sends));
                    if (m_tdata[4] != want.clr)
                        report_mismatch("clear_removal", int'(m_tdata[4]), int'(want.clr));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_gap);
        end
    end

    // ends the run when no channel moves a beat for too long
    initial
    begin
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic test_directed();
        send_gap = 0;
        recv_gap = 0;
        // full climb exit -> reset -> ready -> run, then a double drop
        set_config(3, 4);
        send_report(31, dmaf_pkg::CODE_RESET);
        send_report(3, dmaf_pkg::CODE_RESET);
        send_report(0, dmaf_pkg::CODE_READY);
        send_report(1, dmaf_pkg::CODE_RESET);
        send_report(2, dmaf_pkg::CODE_RESET);
        send_report(1, dmaf_pkg::CODE_RUN);
        send_report(2, dmaf_pkg::CODE_READY);
        send_report(1, dmaf_pkg::CODE_RUN);
        send_report(2, dmaf_pkg::CODE_RESET);
        drain_reports();
        // empty scan
        set_config(31, 0);
        send_report(0, dmaf_pkg::CODE_RESET);
        send_report(31, dmaf_pkg::CODE_READY);
        send_report(5, dmaf_pkg::CODE_EXIT);
        drain_reports();
        // count beyond the table size
        set_config(31, 40);
        send_report(31, dmaf_pkg::CODE_RESET);
        send_report(0, dmaf_pkg::CODE_EXIT);
        send_report(16, dmaf_pkg::CODE_READY);
        send_report(31, dmaf_pkg::CODE_EXIT);
        drain_reports();
        // local slot outside the scanned entries
        set_config(20, 2);
        send_report(0, dmaf_pkg::CODE_RESET);
        send_report(1, dmaf_pkg::CODE_RESET);
        send_report(0, dmaf_pkg::CODE_READY);
        send_report(1, dmaf_pkg::CODE_READY);
        send_report(1, dmaf_pkg::CODE_RUN);
        send_report(0, dmaf_pkg::CODE_EXIT);
        drain_reports();
    endtask

    // one agreement attempt over n slots with occasional stray codes
    task automatic agreement_round(input int n);
        logic [1:0] steps [3];
        int         start;
        logic [1:0] code;
        steps[0] = dmaf_pkg::CODE_RESET;
        steps[1] = dmaf_pkg::CODE_READY;
        steps[2] = dmaf_pkg::CODE_RUN;
        send_report(slot_t'($urandom_range(0, 31)), dmaf_pkg::CODE_RESET);
        for (int p = 0; p < 3; p++)
        begin
            start = $urandom_range(0, n - 1);
            for (int k = 0; k < n; k++)
            begin
                code = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : steps[p];
                send_report(slot_t'((start + k) % n), code);
            end
        end
        repeat ($urandom_range(0, 2))
            send_report(slot_t'($urandom_range(0, n - 1)), dmaf_pkg::CODE_RUN);
        send_report(slot_t'($urandom_range(0, n - 1)),
                    $urandom_range(0, 1) ? dmaf_pkg::CODE_EXIT : dmaf_pkg::CODE_RESET);
    endtask

    task automatic test_agreement(input int s_gap, input int r_gap, input int quota);
        int first;
        int sc;
        int li;
        int n;
        send_gap = s_gap;
        recv_gap = r_gap;
        first    = reports_sent;
        while (reports_sent - first < quota)
        begin
            case ($urandom_range(0, 19))
                0:       sc = 0;
                1:       sc = 32;
                2:       sc = 40;
                default: sc = $urandom_range(1, 6);
            endcase
            n  = (sc == 0) ? 3 : ((sc > 32) ? 32 : sc);
            li = ($urandom_range(0, 9) < 7) ? $urandom_range(0, n - 1) : $urandom_range(0, 31);
            set_config(li, sc);
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    repeat ($urandom_range(1, 5))
                        send_report(slot_t'($urandom_range(0, 31)), 2'($urandom_range(0, 3)));
                end
                else
                    agreement_round(n);
            end
            drain_reports();
        end
    endtask

    // receiver stalls long enough for the block to fill and hold off input
    task automatic test_backpressure();
        send_gap  = 0;
        recv_gap  = 0;
        hold_left = 200;
        repeat (8)
            send_report(slot_t'($urandom_range(0, 31)), 2'($urandom_range(0, 3)));
        drain_reports();
    endtask

    initial
    begin
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        for (int i = 0; i < dmaf_pkg::DEF_MAX_STATIONS; i++)
            flags[i] = dmaf_pkg::CODE_EXIT;
        my_slot      = '0;
        scan_count   = 1;
        mismatches   = 0;
        reports_sent = 0;
        send_gap     = 0;
        recv_gap     = 0;
        hold_left    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_agreement(36, 61, 100);
        test_agreement(61, 36, 100);
        test_agreement(0, 0, 100);
        test_backpressure();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending.size() != 0)
            report_mismatch("results never seen", pending.size(), 0);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
